// File: hdl/ktt_pkg.sv
// ----------------------------------------------------------------------------
// ktt_pkg
// Shared sizes, codes and record types for the keyed track table.
// ----------------------------------------------------------------------------
package ktt_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // result field widths
  localparam int SLOT_W  = 5;
  localparam int TOTAL_W = 6;

  // constants
  localparam logic [31:0] STALE_RESET   = 32'd900000;  // 15 minutes in ms
  localparam logic [12:0] HEADING_LIMIT = 13'd3600;    // 360.0 degrees

  // item actions
  localparam logic ACT_REPORT = 1'b0;
  localparam logic ACT_PRUNE  = 1'b1;

  // result outcomes
  localparam logic [1:0] OUT_FOUND = 2'd0;
  localparam logic [1:0] OUT_NEW   = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;
  localparam logic [1:0] OUT_PRUNE = 2'd3;

  // one table entry as held in memory
  typedef struct packed {
    logic [29:0]        key;
    logic signed [27:0] lat;
    logic signed [28:0] lon;
    logic [31:0]        seen;
    logic [11:0]        heading;
    logic [11:0]        course;
    logic [9:0]         speed;
  } entry_t;

  // latched input item
  typedef struct packed {
    logic [31:0]        now;
    logic [29:0]        identity;
    logic signed [27:0] lat;
    logic signed [28:0] lon;
    logic               th_p;
    logic [12:0]        th;
    logic               cog_p;
    logic [11:0]        cog;
    logic               sog_p;
    logic [9:0]         sog;
  } report_t;

endpackage

// File: hdl/ktt_ram.sv
// ----------------------------------------------------------------------------
// ktt_ram
// Simple dual-port RAM: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ktt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/ktt_update.sv
// ----------------------------------------------------------------------------
// ktt_update
// Merges a report item into an entry: position, time, heading, course, speed.
// ----------------------------------------------------------------------------
module ktt_update (
  input  ktt_pkg::entry_t  old_rec,
  input  ktt_pkg::report_t req,
  output ktt_pkg::entry_t  new_rec
);
  import ktt_pkg::*;

  logic [11:0] heading;

  // heading: usable true heading, else course, else keep
  always_comb begin
    if (req.th_p && (req.th <= HEADING_LIMIT)) begin
      heading = req.th[11:0];
    end else if (req.cog_p) begin
      heading = req.cog;
    end else begin
      heading = old_rec.heading;
    end
  end

  always_comb begin
    new_rec         = old_rec;
    new_rec.key     = req.identity;
    new_rec.lat     = req.lat;
    new_rec.lon     = req.lon;
    new_rec.seen    = req.now;
    new_rec.heading = heading;
    new_rec.course  = req.cog_p ? req.cog : heading;
    if (req.sog_p) begin
      new_rec.speed = req.sog;
    end
  end

endmodule

// File: hdl/keyed_track_table_with_aging_core.sv
// ----------------------------------------------------------------------------
// keyed_track_table_with_aging_core
// Track table keyed by identity, with oldest-entry replacement and pruning.
// ----------------------------------------------------------------------------
// Report: one memory read per valid entry during the key / oldest scan,
//   then one write of the chosen slot.
// Prune: the single read port walks the table; a removed entry is refilled
//   from the tail entry, which is then tested in its place.
// One item at a time; busy is high from accept until the result strobe, which
//   cannot be stalled. Reset (rst, synchronous) empties table, limit 900000.
// ----------------------------------------------------------------------------
module keyed_track_table_with_aging_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [31:0]        now_ms,
  input  logic [29:0]        identity,
  input  logic signed [27:0] lat_udeg,
  input  logic signed [28:0] lon_udeg,
  input  logic               true_heading_present,
  input  logic [12:0]        true_heading_tenths,
  input  logic               cog_present,
  input  logic [11:0]        cog_tenths,
  input  logic               sog_present,
  input  logic [9:0]         sog_tenths,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  output logic               done,
  output logic [1:0]         outcome,
  output logic [4:0]         slot_index,
  output logic [5:0]         track_total,
  output logic [5:0]         removed_total,
  output logic [29:0]        evicted_identity,
  output logic [11:0]        stored_heading,
  output logic [11:0]        stored_course
);
  import ktt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_RWRITE = 3'd2;
  localparam logic [2:0] S_PREAD  = 3'd3;
  localparam logic [2:0] S_PTEST  = 3'd4;
  localparam logic [2:0] S_PMOVE  = 3'd5;

  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

  logic [2:0]       state;
  report_t          req;
  logic [31:0]      stale_limit;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] removed;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic             found;
  logic [IDX_W-1:0] hit_idx;
  entry_t           hit_rec;
  logic [IDX_W-1:0] min_idx;
  logic [31:0]      min_seen;
  logic [29:0]      min_key;

  // memory port signals
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  // report write-back
  logic             full;
  logic [IDX_W-1:0] slot_sel;
  entry_t           old_rec;
  entry_t           new_rec;
  logic [CNT_W-1:0] count_rpt;

  // prune test
  logic [31:0]      age;
  logic             stale;
  logic [CNT_W-1:0] last;

  assign busy = (state != S_IDLE);

  ktt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ktt_update u_update (
    .old_rec (old_rec),
    .req     (req),
    .new_rec (new_rec)
  );

  // slot choice for a report
  always_comb begin
    full      = (count == FULL);
    count_rpt = (!found && !full) ? count + 1'b1 : count;
    if (found) begin
      slot_sel = hit_idx;
    end else if (!full) begin
      slot_sel = count[IDX_W-1:0];
    end else begin
      slot_sel = min_idx;
    end
    // a claimed slot starts zeroed
    old_rec = found ? hit_rec : '0;
  end

  // age with wraparound
  assign age   = req.now - rd_data.seen;
  assign stale = (age > stale_limit);
  assign last  = count - 1'b1;

  // memory access per state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = idx[IDX_W-1:0];
    wr_data = rd_data;
    unique case (state)
      S_SCAN: begin
        rd_en = (idx < count);
      end
      S_PREAD: begin
        rd_en = (idx < count);
      end
      S_PTEST: begin
        // fetch the last entry to fill the hole
        if (stale && (idx != last)) begin
          rd_en   = 1'b1;
          rd_addr = last[IDX_W-1:0];
        end
      end
      S_PMOVE: begin
        wr_en = 1'b1;
      end
      S_RWRITE: begin
        wr_en   = 1'b1;
        wr_addr = slot_sel;
        wr_data = new_rec;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      stale_limit <= STALE_RESET;
      done        <= 1'b0;
      cmp_valid   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wr_en) begin
        stale_limit <= cfg_wr_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req.now      <= now_ms;
            req.identity <= identity;
            req.lat      <= lat_udeg;
            req.lon      <= lon_udeg;
            req.th_p     <= true_heading_present;
            req.th       <= true_heading_tenths;
            req.cog_p    <= cog_present;
            req.cog      <= cog_tenths;
            req.sog_p    <= sog_present;
            req.sog      <= sog_tenths;
            idx          <= '0;
            removed      <= '0;
            found        <= 1'b0;
            cmp_valid    <= 1'b0;
            state        <= (action == ACT_PRUNE) ? S_PREAD : S_SCAN;
          end
        end

        // pipelined scan: issue one read, check the one before
        S_SCAN: begin
          cmp_valid <= rd_en;
          cmp_idx   <= idx[IDX_W-1:0];
          if (rd_en) begin
            idx <= idx + 1'b1;
          end
          if (cmp_valid) begin
            if (!found && (rd_data.key == req.identity)) begin
              found   <= 1'b1;
              hit_idx <= cmp_idx;
              hit_rec <= rd_data;
            end
            // ties keep the lower slot
            if ((cmp_idx == '0) || (rd_data.seen < min_seen)) begin
              min_idx  <= cmp_idx;
              min_seen <= rd_data.seen;
              min_key  <= rd_data.key;
            end
          end
          if (!rd_en && !cmp_valid) begin
            state <= S_RWRITE;
          end
        end

        S_RWRITE: begin
          count            <= count_rpt;
          done             <= 1'b1;
          outcome          <= found ? OUT_FOUND : (full ? OUT_EVICT : OUT_NEW);
          slot_index       <= SLOT_W'(slot_sel);
          track_total      <= TOTAL_W'(count_rpt);
          removed_total    <= '0;
          evicted_identity <= (!found && full) ? min_key : '0;
          stored_heading   <= new_rec.heading;
          stored_course    <= new_rec.course;
          state            <= S_IDLE;
        end

        S_PREAD: begin
          if (idx >= count) begin
            done             <= 1'b1;
            outcome          <= OUT_PRUNE;
            slot_index       <= '0;
            track_total      <= TOTAL_W'(count);
            removed_total    <= TOTAL_W'(removed);
            evicted_identity <= '0;
            stored_heading   <= '0;
            stored_course    <= '0;
            state            <= S_IDLE;
          end else begin
            state <= S_PTEST;
          end
        end

        S_PTEST: begin
          if (!stale) begin
            idx   <= idx + 1'b1;
            state <= S_PREAD;
          end else if (idx == last) begin
            // removing the last entry itself
            count   <= last;
            removed <= removed + 1'b1;
            state   <= S_PREAD;
          end else begin
            state <= S_PMOVE;
          end
        end

        // last entry lands in the hole, then gets tested there
        S_PMOVE: begin
          count   <= last;
          removed <= removed + 1'b1;
          state   <= S_PREAD;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("valid count above table size");

  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en && (rd_addr == wr_addr)))
    else $error("read and write of the same entry in one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still working");

  a_new_slot_tail: assert property (@(posedge clk) disable iff (rst)
    (done && (outcome == OUT_NEW)) |-> (slot_index == SLOT_W'(track_total - 1'b1)))
    else $error("new entry not placed at the table tail");

  a_prune_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (outcome == OUT_PRUNE)) |-> ((slot_index == '0) && (evicted_identity == '0)))
    else $error("prune result carries report fields");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_RWRITE) && !found && full |=> (count == FULL))
    else $error("replacement changed the table size");

endmodule
